// ===== rtl/core/ipalc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipalc_pkg
// Shared types and constants of the IP address allowlist classifier: table
// geometry, protocol numbers, result codes and the controller interface.
// ----------------------------------------------------------------------------
package ipalc_pkg;

    // Candidate table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Packet length limits in bytes.
    localparam logic [15:0] V4_HDR_BYTES     = 16'd20;
    localparam logic [15:0] V6_HDR_BYTES     = 16'd40;
    localparam logic [15:0] MAX_PACKET_BYTES = 16'd2048;

    // Header codes.
    localparam logic [3:0] IP_VERSION_6 = 4'd6;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMPV6 = 8'd58;

    // Item function codes.
    localparam logic FUNC_WRITE    = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ENABLED = 1'b0;
    localparam logic CFG_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        ACT_PASS  = 2'd0,
        ACT_DROP  = 2'd1,
        ACT_QUEUE = 2'd2,
        ACT_WRITE = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        CAUSE_MARKED   = 4'd0,
        CAUSE_DISABLED = 4'd1,
        CAUSE_SHORT    = 4'd2,
        CAUSE_ICMPV6   = 4'd3,
        CAUSE_PROTOCOL = 4'd4,
        CAUSE_NOMATCH  = 4'd5,
        CAUSE_OVERSIZE = 4'd6,
        CAUSE_V6TRUNC  = 4'd7,
        CAUSE_QUEUED   = 4'd8,
        CAUSE_WRITE    = 4'd9
    } cause_t;

    // One candidate table entry.
    typedef struct packed {
        logic        is_v6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic write_entry;
        logic scan_start;
        logic scan_run;
        logic load_result;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_write;
        logic need_scan;
        logic hit;
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/core/ip_address_allowlist_classifier_core.sv =====
// ----------------------------------------------------------------------------
// ip_address_allowlist_classifier_core
// Classifies packets by their extracted header fields against an allowlist
// table of IPv4 and IPv6 addresses, and writes entries of that table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transaction:
//   either a table entry write (func 0) or a packet to classify (func 1).
//   Output channel (out_valid / out_stall) returns exactly one result
//   transaction per item: action, cause and queue_id.
//   A table write or a packet settled by its header goes from evaluation
//   straight to the result. A packet that needs a lookup first scans the
//   entries in use, read one entry per cycle through a single read port.
//   One item is worked on at a time; the next is accepted in the cycle after
//   the previous result is loaded into the output register, even while that
//   result still waits for the receiver.
//   When the receiver stalls, the result holds in the output register and a
//   further result waits inside the block, so in_stall stays high.
//   Reset clears the control state, the configuration (filter disabled,
//   no entries in use) and sets the next packet id to 1. The table keeps no
//   reset value; entries must be written before they are counted in use.
//   The user makes configuration writes (cfg_we, cfg_index, cfg_data) only
//   while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ip_address_allowlist_classifier_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [5:0]  entry_index,
    input  logic        skip_mark,
    input  logic        outbound,
    input  logic [15:0] packet_length,
    input  logic [3:0]  ip_version,
    input  logic [7:0]  next_protocol,
    input  logic [63:0] src_high,
    input  logic [63:0] src_low,
    input  logic [63:0] dst_high,
    input  logic [63:0] dst_low,
    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  action,
    output logic [3:0]  cause,
    output logic [31:0] queue_id
);

    ipalc_pkg::cmd_t cmd;
    ipalc_pkg::sts_t sts;

    // Sequencer.
    ipalc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, comparator and result path.
    ipalc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .entry_index   (entry_index),
        .skip_mark     (skip_mark),
        .outbound      (outbound),
        .packet_length (packet_length),
        .ip_version    (ip_version),
        .next_protocol (next_protocol),
        .src_high      (src_high),
        .src_low       (src_low),
        .dst_high      (dst_high),
        .dst_low       (dst_low),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .action        (action),
        .cause         (cause),
        .queue_id      (queue_id)
    );

endmodule

// ===== rtl/core/ipalc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ipalc_ctrl
// Sequencer of the classifier: accepts one transaction, evaluates it, runs
// the table scan when needed and hands the result to the output register.
// ----------------------------------------------------------------------------
module ipalc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ipalc_pkg::sts_t sts,
    output ipalc_pkg::cmd_t cmd
);

    ipalc_pkg::state_t state_reg;
    ipalc_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipalc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ipalc_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ipalc_pkg::S_EVAL;
                end
            end
            ipalc_pkg::S_EVAL:
            begin
                if (sts.is_write)
                begin
                    cmd.write_entry = 1'b1;
                    state_next      = ipalc_pkg::S_RESULT;
                end
                else if (sts.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ipalc_pkg::S_SCAN;
                end
                else
                begin
                    state_next = ipalc_pkg::S_RESULT;
                end
            end
            ipalc_pkg::S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.hit || sts.scan_done)
                begin
                    state_next = ipalc_pkg::S_RESULT;
                end
            end
            ipalc_pkg::S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ipalc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ipalc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/ipalc_datapath.sv =====
// ----------------------------------------------------------------------------
// ipalc_datapath
// Holds the captured transaction, the configuration registers, the candidate
// table memory with its scan pointer and comparator, the id counter and the
// output register.
// ----------------------------------------------------------------------------
module ipalc_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  ipalc_pkg::cmd_t cmd,
    output ipalc_pkg::sts_t sts,
    // Configuration port.
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [6:0]      cfg_data,
    // Input payload.
    input  logic            func,
    input  logic [5:0]      entry_index,
    input  logic            skip_mark,
    input  logic            outbound,
    input  logic [15:0]     packet_length,
    input  logic [3:0]      ip_version,
    input  logic [7:0]      next_protocol,
    input  logic [63:0]     src_high,
    input  logic [63:0]     src_low,
    input  logic [63:0]     dst_high,
    input  logic [63:0]     dst_low,
    // Output channel.
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      action,
    output logic [3:0]      cause,
    output logic [31:0]     queue_id
);

    // Captured transaction.
    logic        func_reg;
    logic [5:0]  entry_index_reg;
    logic        skip_mark_reg;
    logic        outbound_reg;
    logic [15:0] packet_length_reg;
    logic [3:0]  ip_version_reg;
    logic [7:0]  next_protocol_reg;
    logic [63:0] src_high_reg;
    logic [63:0] src_low_reg;
    logic [63:0] dst_high_reg;
    logic [63:0] dst_low_reg;

    // Configuration.
    logic                       enabled_reg;
    logic [ipalc_pkg::CNT_W-1:0] count_reg;

    // Table and scan.
    ipalc_pkg::entry_t           table_mem [ipalc_pkg::TABLE_DEPTH];
    ipalc_pkg::entry_t           rd_data_reg;
    logic                        rd_valid_reg;
    logic [ipalc_pkg::CNT_W-1:0] scan_idx_reg;
    logic                        found_reg;

    // Id counter and output register.
    logic [31:0]        next_id_reg;
    logic               out_valid_reg;
    ipalc_pkg::action_t action_reg;
    ipalc_pkg::cause_t  cause_reg;
    logic [31:0]        queue_id_reg;

    logic               key_v6;
    logic [63:0]        key_high;
    logic [63:0]        key_low;
    logic               entry_match;
    ipalc_pkg::action_t res_action;
    ipalc_pkg::cause_t  res_cause;
    logic               early_done;

    // Capture the transaction payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg          <= func;
            entry_index_reg   <= entry_index;
            skip_mark_reg     <= skip_mark;
            outbound_reg      <= outbound;
            packet_length_reg <= packet_length;
            ip_version_reg    <= ip_version;
            next_protocol_reg <= next_protocol;
            src_high_reg      <= src_high;
            src_low_reg       <= src_low;
            dst_high_reg      <= dst_high;
            dst_low_reg       <= dst_low;
        end
    end

    // Configuration registers; an entry count above the table depth is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b0;
            count_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ipalc_pkg::CFG_ENABLED:
                begin
                    enabled_reg <= cfg_data[0];
                end
                ipalc_pkg::CFG_COUNT:
                begin
                    if (cfg_data <= 7'(ipalc_pkg::TABLE_DEPTH))
                    begin
                        count_reg <= ipalc_pkg::CNT_W'(cfg_data);
                    end
                end
                default:
                begin
                    enabled_reg <= enabled_reg;
                end
            endcase
        end
    end

    // Table memory write port.
    always_ff @(posedge clk)
    begin
        if (cmd.write_entry)
        begin
            table_mem[entry_index_reg] <= '{
                is_v6:     (ip_version_reg == ipalc_pkg::IP_VERSION_6),
                addr_high: src_high_reg,
                addr_low:  src_low_reg
            };
        end
    end

    // Table memory read port, one entry per scan cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_run)
        begin
            rd_data_reg <= table_mem[scan_idx_reg[ipalc_pkg::IDX_W-1:0]];
        end
    end

    // Scan pointer, read valid flag and sticky match flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_run)
        begin
            found_reg <= entry_match;
            if (scan_idx_reg < count_reg)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                rd_valid_reg <= 1'b1;
            end
            else
            begin
                rd_valid_reg <= 1'b0;
            end
        end
    end

    // Lookup key: destination for outbound traffic, source for inbound.
    assign key_v6   = (ip_version_reg == ipalc_pkg::IP_VERSION_6);
    assign key_high = outbound_reg ? dst_high_reg : src_high_reg;
    assign key_low  = outbound_reg ? dst_low_reg : src_low_reg;

    // Compare the entry read in the previous cycle; IPv4 uses the low 32 bits.
    always_comb
    begin
        entry_match = 1'b0;
        if (rd_valid_reg && (rd_data_reg.is_v6 == key_v6))
        begin
            if (key_v6)
            begin
                entry_match = (rd_data_reg.addr_high == key_high) &&
                              (rd_data_reg.addr_low == key_low);
            end
            else
            begin
                entry_match = (rd_data_reg.addr_low[31:0] == key_low[31:0]);
            end
        end
    end

    // Verdict in priority order; the table result decides the last steps.
    always_comb
    begin
        early_done = 1'b1;
        res_action = ipalc_pkg::ACT_PASS;
        res_cause  = ipalc_pkg::CAUSE_MARKED;
        if (func_reg == ipalc_pkg::FUNC_WRITE)
        begin
            res_action = ipalc_pkg::ACT_WRITE;
            res_cause  = ipalc_pkg::CAUSE_WRITE;
        end
        else if (skip_mark_reg)
        begin
            res_action = ipalc_pkg::ACT_PASS;
            res_cause  = ipalc_pkg::CAUSE_MARKED;
        end
        else if (!enabled_reg)
        begin
            res_action = ipalc_pkg::ACT_PASS;
            res_cause  = ipalc_pkg::CAUSE_DISABLED;
        end
        else if (packet_length_reg < ipalc_pkg::V4_HDR_BYTES)
        begin
            res_action = ipalc_pkg::ACT_PASS;
            res_cause  = ipalc_pkg::CAUSE_SHORT;
        end
        else if (key_v6 && (packet_length_reg < ipalc_pkg::V6_HDR_BYTES))
        begin
            res_action = ipalc_pkg::ACT_DROP;
            res_cause  = ipalc_pkg::CAUSE_V6TRUNC;
        end
        else if (key_v6 && (next_protocol_reg == ipalc_pkg::PROTO_ICMPV6))
        begin
            res_action = ipalc_pkg::ACT_PASS;
            res_cause  = ipalc_pkg::CAUSE_ICMPV6;
        end
        else if ((next_protocol_reg != ipalc_pkg::PROTO_TCP) &&
                 (next_protocol_reg != ipalc_pkg::PROTO_UDP))
        begin
            res_action = ipalc_pkg::ACT_DROP;
            res_cause  = ipalc_pkg::CAUSE_PROTOCOL;
        end
        else
        begin
            early_done = 1'b0;
            if (!found_reg)
            begin
                res_action = ipalc_pkg::ACT_DROP;
                res_cause  = ipalc_pkg::CAUSE_NOMATCH;
            end
            else if (packet_length_reg > ipalc_pkg::MAX_PACKET_BYTES)
            begin
                res_action = ipalc_pkg::ACT_DROP;
                res_cause  = ipalc_pkg::CAUSE_OVERSIZE;
            end
            else
            begin
                res_action = ipalc_pkg::ACT_QUEUE;
                res_cause  = ipalc_pkg::CAUSE_QUEUED;
            end
        end
    end

    // Id counter, advanced by each queued packet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_id_reg <= 32'd1;
        end
        else if (cmd.load_result && (res_action == ipalc_pkg::ACT_QUEUE))
        begin
            next_id_reg <= next_id_reg + 32'd1;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            action_reg   <= res_action;
            cause_reg    <= res_cause;
            queue_id_reg <= (res_action == ipalc_pkg::ACT_QUEUE) ? next_id_reg : 32'd0;
        end
    end

    // Status toward the controller.
    assign sts.is_write  = (func_reg == ipalc_pkg::FUNC_WRITE);
    assign sts.need_scan = !early_done;
    assign sts.hit       = entry_match;
    assign sts.scan_done = (scan_idx_reg >= count_reg) && !entry_match;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign action    = action_reg;
    assign cause     = cause_reg;
    assign queue_id  = queue_id_reg;

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IP address allowlist classifier core. Table
// writes and packet transactions are queued, driven on the input channel
// with random gaps, and each result is compared against a cycle-free
// predictor of the classification order, the lookup and the id counter.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ipalc_pkg::*;

    // One input transaction as presented on the payload ports.
    typedef struct {
        logic        func;
        logic [5:0]  entry_index;
        logic        skip_mark;
        logic        outbound;
        logic [15:0] packet_length;
        logic [3:0]  ip_version;
        logic [7:0]  next_protocol;
        logic [63:0] src_high;
        logic [63:0] src_low;
        logic [63:0] dst_high;
        logic [63:0] dst_low;
    } pkt_item_t;

    // One result transaction.
    typedef struct {
        action_t     action;
        cause_t      cause;
        logic [31:0] queue_id;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [5:0]  entry_index;
    logic        skip_mark;
    logic        outbound;
    logic [15:0] packet_length;
    logic [3:0]  ip_version;
    logic [7:0]  next_protocol;
    logic [63:0] src_high;
    logic [63:0] src_low;
    logic [63:0] dst_high;
    logic [63:0] dst_low;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  action;
    logic [3:0]  cause;
    logic [31:0] queue_id;

    // Predictor copy of the block state.
    logic [63:0] allow_hi [TABLE_DEPTH];
    logic [63:0] allow_lo [TABLE_DEPTH];
    logic        allow_v6 [TABLE_DEPTH];
    logic [31:0] next_queue_id;
    logic        filter_on;
    logic [6:0]  entries_in_use;

    pkt_item_t   pending_items[$];
    verdict_t    expected_verdicts[$];
    pkt_item_t   drive_item;
    logic        in_fire;
    int unsigned issued_count;
    int unsigned accepted_count;
    int unsigned mismatch_count;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    ip_address_allowlist_classifier_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .entry_index   (entry_index),
        .skip_mark     (skip_mark),
        .outbound      (outbound),
        .packet_length (packet_length),
        .ip_version    (ip_version),
        .next_protocol (next_protocol),
        .src_high      (src_high),
        .src_low       (src_low),
        .dst_high      (dst_high),
        .dst_low       (dst_low),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .action        (action),
        .cause         (cause),
        .queue_id      (queue_id)
    );

    // Clock generation.
    always #1 clk = ~clk;

    // Works out the result of one transaction and advances the predictor
    // state: table contents on a write, the id counter on a queued packet.
    function automatic verdict_t classify_item(pkt_item_t it);
        verdict_t    v;
        logic        is_v6;
        logic        hit;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        int          i;
        v.action    = ACT_PASS;
        v.cause     = CAUSE_MARKED;
        v.queue_id  = '0;
        is_v6       = (it.ip_version == IP_VERSION_6);
        if (it.func == FUNC_WRITE)
        begin
            allow_hi[it.entry_index] = it.src_high;
            allow_lo[it.entry_index] = it.src_low;
            allow_v6[it.entry_index] = is_v6;
            v.action = ACT_WRITE;
            v.cause  = CAUSE_WRITE;
        end
        else if (it.skip_mark)
        begin
            v.cause = CAUSE_MARKED;
        end
        else if (!filter_on)
        begin
            v.cause = CAUSE_DISABLED;
        end
        else if (it.packet_length < V4_HDR_BYTES)
        begin
            v.cause = CAUSE_SHORT;
        end
        else if (is_v6 && it.packet_length < V6_HDR_BYTES)
        begin
            v.action = ACT_DROP;
            v.cause  = CAUSE_V6TRUNC;
        end
        else if (is_v6 && it.next_protocol == PROTO_ICMPV6)
        begin
            v.cause = CAUSE_ICMPV6;
        end
        else if (it.next_protocol != PROTO_TCP && it.next_protocol != PROTO_UDP)
        begin
            v.action = ACT_DROP;
            v.cause  = CAUSE_PROTOCOL;
        end
        else
        begin
            key_hi = it.outbound ? it.dst_high : it.src_high;
            key_lo = it.outbound ? it.dst_low : it.src_low;
            hit    = 1'b0;
            // The family must agree; IPv4 compares only the low 32 bits.
            for (i = 0; i < entries_in_use; i++)
            begin
                if (allow_v6[i] == is_v6)
                begin
                    if (is_v6 && allow_hi[i] == key_hi && allow_lo[i] == key_lo)
                        hit = 1'b1;
                    if (!is_v6 && allow_lo[i][31:0] == key_lo[31:0])
                        hit = 1'b1;
                end
            end
            if (!hit)
            begin
                v.action = ACT_DROP;
                v.cause  = CAUSE_NOMATCH;
            end
            else if (it.packet_length > MAX_PACKET_BYTES)
            begin
                v.action = ACT_DROP;
                v.cause  = CAUSE_OVERSIZE;
            end
            else
            begin
                v.action      = ACT_QUEUE;
                v.cause       = CAUSE_QUEUED;
                v.queue_id    = next_queue_id;
                next_queue_id = next_queue_id + 32'd1;
            end
        end
        return v;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // Any version nibble other than 6 is IPv4.
    function automatic logic [3:0] v4_nibble();
        logic [3:0] n;
        n = 4'($urandom_range(15));
        if (n == IP_VERSION_6)
            n = 4'd4;
        return n;
    endfunction

    // Fields that a transaction does not use still carry random values.
    function automatic pkt_item_t random_fill();
        pkt_item_t it;
        it.func          = 1'($urandom_range(1));
        it.entry_index   = 6'($urandom_range(63));
        it.skip_mark     = 1'($urandom_range(1));
        it.outbound      = 1'($urandom_range(1));
        it.packet_length = 16'($urandom_range(65535));
        it.ip_version    = 4'($urandom_range(15));
        it.next_protocol = 8'($urandom_range(255));
        it.src_high      = rnd64();
        it.src_low       = rnd64();
        it.dst_high      = rnd64();
        it.dst_low       = rnd64();
        return it;
    endfunction

    function automatic pkt_item_t entry_write(logic [5:0] idx, logic [3:0] ver,
                                              logic [63:0] hi, logic [63:0] lo);
        pkt_item_t it;
        it             = random_fill();
        it.func        = FUNC_WRITE;
        it.entry_index = idx;
        it.ip_version  = ver;
        it.src_high    = hi;
        it.src_low     = lo;
        return it;
    endfunction

    function automatic pkt_item_t classify_pkt(logic mark, logic outb, logic [15:0] len,
                                               logic [3:0] ver, logic [7:0] proto,
                                               logic [63:0] sh, logic [63:0] sl,
                                               logic [63:0] dh, logic [63:0] dl);
        pkt_item_t it;
        it               = random_fill();
        it.func          = FUNC_CLASSIFY;
        it.skip_mark     = mark;
        it.outbound      = outb;
        it.packet_length = len;
        it.ip_version    = ver;
        it.next_protocol = proto;
        it.src_high      = sh;
        it.src_low       = sl;
        it.dst_high      = dh;
        it.dst_low       = dl;
        return it;
    endfunction

    function automatic pkt_item_t random_entry_write(logic [5:0] idx);
        logic [3:0] ver;
        ver = $urandom_range(1) ? IP_VERSION_6 : v4_nibble();
        return entry_write(idx, ver, rnd64(), rnd64());
    endfunction

    // Mostly well-formed packets aimed at table entries in use, with some
    // table writes, marked packets and malformed headers mixed in.
    function automatic pkt_item_t random_item();
        int          lr;
        int          pr;
        int          n;
        int          k;
        logic        mark;
        logic        outb;
        logic [15:0] len;
        logic [7:0]  proto;
        logic [3:0]  ver;
        logic [63:0] hi;
        logic [63:0] lo;
        if ($urandom_range(99) < 8)
            return random_entry_write(6'($urandom_range(63)));
        mark = ($urandom_range(99) < 5);
        outb = 1'($urandom_range(1));
        lr   = $urandom_range(99);
        if (lr < 70)
            len = 16'($urandom_range(2048, 40));
        else if (lr < 80)
            len = 16'($urandom_range(39));
        else if (lr < 90)
            len = 16'($urandom_range(65535, 2049));
        else
            len = 16'($urandom_range(65535));
        pr = $urandom_range(99);
        if (pr < 80)
            proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
        else if (pr < 85)
            proto = PROTO_ICMPV6;
        else
            proto = 8'($urandom_range(255));
        if ($urandom_range(99) < 75)
        begin
            n = (entries_in_use == 0) ? TABLE_DEPTH : int'(entries_in_use);
            k = $urandom_range(n - 1);
            if (allow_v6[k])
            begin
                ver = IP_VERSION_6;
                hi  = allow_hi[k];
                lo  = allow_lo[k];
            end
            else
            begin
                ver = v4_nibble();
                hi  = rnd64();
                lo  = {$urandom(), allow_lo[k][31:0]};
            end
        end
        else
        begin
            ver = 4'($urandom_range(15));
            hi  = rnd64();
            lo  = rnd64();
        end
        if (outb)
            return classify_pkt(mark, 1'b1, len, ver, proto, rnd64(), rnd64(), hi, lo);
        return classify_pkt(mark, 1'b0, len, ver, proto, hi, lo, rnd64(), rnd64());
    endfunction

    task automatic issue(pkt_item_t it);
        pending_items.push_back(it);
        issued_count++;
    endtask

    // Waits until every queued transaction was accepted and answered.
    task automatic wait_idle();
        @(negedge clk);
        while (accepted_count != issued_count || expected_verdicts.size() != 0)
            @(negedge clk);
    endtask

    // Register write, mirrored into the predictor; an oversize count is ignored.
    task automatic write_cfg(logic idx, logic [6:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cfg_data <= 7'($urandom_range(127));
        if (idx == CFG_ENABLED)
            filter_on = data[0];
        else if (data <= TABLE_DEPTH)
            entries_in_use = data;
    endtask

    task automatic set_idling(int unsigned pattern);
        case (pattern % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
        endcase
    endtask

    // Driver: presents the next pending transaction at the falling edge and
    // holds it until accepted.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    drive_item = pending_items.pop_front();
                    in_valid      <= 1'b1;
                    func          <= drive_item.func;
                    entry_index   <= drive_item.entry_index;
                    skip_mark     <= drive_item.skip_mark;
                    outbound      <= drive_item.outbound;
                    packet_length <= drive_item.packet_length;
                    ip_version    <= drive_item.ip_version;
                    next_protocol <= drive_item.next_protocol;
                    src_high      <= drive_item.src_high;
                    src_low       <= drive_item.src_low;
                    dst_high      <= drive_item.dst_high;
                    dst_low       <= drive_item.dst_low;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Monitor: predicts on input acceptance and checks each accepted result
    // against the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n)
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                expected_verdicts.push_back(classify_item(drive_item));
                accepted_count++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected result: action %0d, cause %0d, queue_id %0d",
                           action, cause, queue_id);
                    mismatch_count++;
                end
                else
                begin
                    exp_v = expected_verdicts.pop_front();
                    if (action !== exp_v.action)
                    begin
                        $error("action mismatch: expected %0d, actual %0d",
                               exp_v.action, action);
                        mismatch_count++;
                    end
                    if (cause !== exp_v.cause)
                    begin
                        $error("cause mismatch: expected %0d, actual %0d",
                               exp_v.cause, cause);
                        mismatch_count++;
                    end
                    if (queue_id !== exp_v.queue_id)
                    begin
                        $error("queue_id mismatch: expected %0d, actual %0d",
                               exp_v.queue_id, queue_id);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        logic [31:0] a4;
        logic [63:0] a4_lo;
        logic [63:0] v6_hi;
        logic [63:0] v6_lo;
        int          p;
        bit          en_list [6];
        logic [6:0]  cnt_list [6];

        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_ENABLED;
        cfg_data       = '0;
        in_valid       = 1'b0;
        func           = FUNC_WRITE;
        entry_index    = '0;
        skip_mark      = 1'b0;
        outbound       = 1'b0;
        packet_length  = '0;
        ip_version     = '0;
        next_protocol  = '0;
        src_high       = '0;
        src_low        = '0;
        dst_high       = '0;
        dst_low        = '0;
        out_stall      = 1'b0;
        in_fire        = 1'b0;
        issued_count   = 0;
        accepted_count = 0;
        mismatch_count = 0;
        next_queue_id  = 32'd1;
        filter_on      = 1'b0;
        entries_in_use = '0;
        set_idling(0);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: a small table, then each step of the decision order.
        a4    = 32'hC0A8_0001;
        a4_lo = {32'd0, a4};
        v6_hi = 64'h2001_0DB8_0000_0000;
        v6_lo = 64'h0000_0000_0000_0001;
        issue(entry_write(6'd0, 4'd4, rnd64(), {$urandom(), a4}));
        issue(entry_write(6'd1, IP_VERSION_6, '1, '1));
        issue(entry_write(6'd2, 4'hF, rnd64(), {$urandom(), 32'hFFFF_FFFF}));
        issue(entry_write(6'd3, IP_VERSION_6, v6_hi, v6_lo));
        issue(entry_write(6'd63, 4'd0, rnd64(), {$urandom(), 32'h0A00_0001}));
        // Filter still disabled after reset; the mark is tested first.
        issue(classify_pkt(1'b0, 1'b0, 16'd100, 4'd4, PROTO_TCP, '0, a4_lo, '0, '0));
        issue(classify_pkt(1'b1, 1'b0, 16'd100, 4'd4, PROTO_TCP, '0, a4_lo, '0, '0));
        wait_idle();
        write_cfg(CFG_ENABLED, 7'b000_0001);
        write_cfg(CFG_COUNT, 7'd4);
        issue(classify_pkt(1'b1, 1'b0, 16'd100, 4'd4, PROTO_TCP, '0, a4_lo, '0, '0));
        issue(classify_pkt(1'b0, 1'b0, 16'd0, 4'd4, PROTO_TCP, '0, a4_lo, '0, '0));
        issue(classify_pkt(1'b0, 1'b0, 16'd19, IP_VERSION_6, PROTO_TCP, v6_hi, v6_lo,
                           '0, '0));
        issue(classify_pkt(1'b0, 1'b0, 16'd20, IP_VERSION_6, PROTO_TCP, v6_hi, v6_lo,
                           '0, '0));
        issue(classify_pkt(1'b0, 1'b0, 16'd39, IP_VERSION_6, PROTO_UDP, v6_hi, v6_lo,
                           '0, '0));
        issue(classify_pkt(1'b0, 1'b0, 16'd40, IP_VERSION_6, PROTO_ICMPV6, v6_hi, v6_lo,
                           '0, '0));
        issue(classify_pkt(1'b0, 1'b0, 16'd40, 4'd4, PROTO_ICMPV6, '0, a4_lo, '0, '0));
        issue(classify_pkt(1'b0, 1'b0, 16'hFFFF, 4'd4, 8'd0, '0, a4_lo, '0, '0));
        issue(classify_pkt(1'b0, 1'b0, 16'd60, 4'd4, 8'hFF, '0, a4_lo, '0, '0));
        // Matches on the low 32 bits only, with and without an odd nibble.
        issue(classify_pkt(1'b0, 1'b0, 16'd20, 4'd4, PROTO_TCP, rnd64(),
                           {$urandom(), a4}, '0, '0));
        issue(classify_pkt(1'b0, 1'b1, 16'd2048, 4'd0, PROTO_UDP, '0, '0, rnd64(),
                           {$urandom(), 32'hFFFF_FFFF}));
        // Family mismatch, oversize after a match, and misses.
        issue(classify_pkt(1'b0, 1'b0, 16'd80, IP_VERSION_6, PROTO_UDP, '0, a4_lo,
                           '0, '0));
        issue(classify_pkt(1'b0, 1'b1, 16'hFFFF, IP_VERSION_6, PROTO_UDP, '0, '0, '1, '1));
        issue(classify_pkt(1'b0, 1'b0, 16'd2048, IP_VERSION_6, PROTO_TCP, v6_hi, v6_lo,
                           '0, '0));
        issue(classify_pkt(1'b0, 1'b0, 16'd2049, 4'd4, PROTO_TCP, '0, a4_lo, '0, '0));
        issue(classify_pkt(1'b0, 1'b1, 16'd100, 4'd4, PROTO_TCP, '0, a4_lo, '0,
                           64'h0000_0000_0B00_0001));
        issue(classify_pkt(1'b0, 1'b0, 16'd100, 4'd4, PROTO_UDP, '0,
                           64'h0000_0000_0A00_0001, '0, '0));
        issue(classify_pkt(1'b0, 1'b0, 16'd100, IP_VERSION_6, PROTO_TCP, v6_hi,
                           v6_lo + 64'd1, '0, '0));
        wait_idle();

        // Fill the whole table so that any count can be used afterwards.
        set_idling(3);
        for (p = 0; p < TABLE_DEPTH; p++)
            issue(random_entry_write(6'(p)));
        wait_idle();

        // Random phases over several settings, the extremes among them.
        en_list  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        cnt_list = '{7'd64, 7'd1, 7'($urandom_range(63, 2)), 7'd64, 7'd0, 7'd64};
        for (p = 0; p < 6; p++)
        begin
            set_idling(p);
            write_cfg(CFG_ENABLED, {6'($urandom_range(63)), en_list[p]});
            write_cfg(CFG_COUNT, cnt_list[p]);
            // A count beyond the table is ignored by the block.
            if (p == 1 || p == 2)
                write_cfg(CFG_COUNT, 7'($urandom_range(127, 65)));
            if (p == 5)
                write_cfg(CFG_COUNT, 7'd127);
            repeat (60) issue(random_item());
            wait_idle();
        end

        repeat (80) @(posedge clk);
        if (expected_verdicts.size() != 0)
        begin
            $error("%0d result transactions never arrived", expected_verdicts.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
